FILE: rtl/cbsg_pkg.sv
// Shared types and constants for the bit-serial CRC generator.
package cbsg_pkg;

	// Width of the configuration register index.
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_WIDTH = 2'd1;

	// Field widths and register reset values.
	localparam int unsigned POLY_W = 32;
	localparam int unsigned CW_W   = 6;
	localparam logic [POLY_W-1:0] GEN_POLY_RST  = 32'd3;
	localparam logic [CW_W-1:0]   CRC_WIDTH_RST = 6'd3;

	// One message bit as it waits between the front and back ends.
	typedef struct packed {
		logic data;
		logic last;
	} item_t;

	// Back-end sequencer states.
	typedef enum logic {
		ST_RUN,
		ST_DRAIN
	} back_state_t;

endpackage

FILE: rtl/cbsg_front.sv
// Front end: accepts message bits into a two-entry queue for the back end.
module cbsg_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic           data_bit,
	input  logic           last_bit,
	output logic           item_valid,
	output cbsg_pkg::item_t item,
	input  logic           item_take
);

	cbsg_pkg::item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= '{data: data_bit, last: last_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/cbsg_back.sv
// Back end: remainder register, check-bit drain and the result register.
module cbsg_back #(
	parameter int unsigned MAX_CRC_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  cbsg_pkg::item_t               item,
	output logic                          item_take,
	input  logic [cbsg_pkg::POLY_W-1:0]   gen_poly,
	input  logic [cbsg_pkg::CW_W-1:0]     crc_width,
	output logic                          empty,
	input  logic                          pop,
	output logic                          code_bit,
	output logic                          end_of_code
);

	localparam int unsigned IDX_W = (MAX_CRC_WIDTH > 1) ? $clog2(MAX_CRC_WIDTH) : 1;
	localparam int unsigned W_W   = $clog2(MAX_CRC_WIDTH + 1);

	cbsg_pkg::back_state_t state_q, state_d;
	logic [MAX_CRC_WIDTH-1:0] rem_q, rem_d;
	logic [IDX_W-1:0]         cnt_q, cnt_d;
	logic                     out_valid_q, out_valid_d;
	logic                     out_bit_q, out_end_q;
	logic                     out_bit_d, out_end_d;
	logic                     load_out;
	logic                     advance;

	logic [W_W-1:0]                      w_eff;
	logic [IDX_W-1:0]                    wm1;
	logic [MAX_CRC_WIDTH-1:0]            mask;
	logic [MAX_CRC_WIDTH+cbsg_pkg::POLY_W-1:0] poly_ext;
	logic [MAX_CRC_WIDTH-1:0]            poly_m;
	logic [MAX_CRC_WIDTH-1:0]            rem_m;
	logic [MAX_CRC_WIDTH-1:0]            rem_step;
	logic                                fb;

	// Degree is clamped to the range the remainder register can hold.
	always_comb begin
		if (crc_width == '0) begin
			w_eff = W_W'(1);
		end else if (7'(crc_width) > 7'(MAX_CRC_WIDTH)) begin
			w_eff = W_W'(MAX_CRC_WIDTH);
		end else begin
			w_eff = W_W'(crc_width);
		end
		wm1 = IDX_W'(w_eff - W_W'(1));
		for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
			mask[i] = (i < int'(w_eff));
		end
	end

	assign poly_ext = {{MAX_CRC_WIDTH{1'b0}}, gen_poly};
	assign poly_m   = poly_ext[MAX_CRC_WIDTH-1:0] & mask;
	assign rem_m    = rem_q & mask;
	assign fb       = item.data ^ rem_m[wm1];
	assign rem_step = ((rem_m << 1) & mask) ^ (fb ? poly_m : '0);

	assign advance   = !out_valid_q || pop;
	assign item_take = (state_q == cbsg_pkg::ST_RUN) && item_valid && advance;

	always_comb begin
		state_d   = state_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		load_out  = 1'b0;
		out_bit_d = 1'b0;
		out_end_d = 1'b0;
		case (state_q)
			cbsg_pkg::ST_RUN: begin
				if (item_take) begin
					load_out  = 1'b1;
					out_bit_d = item.data;
					rem_d     = rem_step;
					if (item.last) begin
						state_d = cbsg_pkg::ST_DRAIN;
						cnt_d   = wm1;
					end
				end
			end
			cbsg_pkg::ST_DRAIN: begin
				// Check bits leave most significant first; the register clears
				// with the final one.
				if (advance) begin
					load_out  = 1'b1;
					out_bit_d = rem_q[cnt_q];
					if (cnt_q == '0) begin
						out_end_d = 1'b1;
						rem_d     = '0;
						state_d   = cbsg_pkg::ST_RUN;
					end else begin
						cnt_d = cnt_q - IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = cbsg_pkg::ST_RUN;
			end
		endcase
		out_valid_d = load_out || (out_valid_q && !pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbsg_pkg::ST_RUN;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rem_q       <= rem_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_bit_q <= out_bit_d;
			out_end_q <= out_end_d;
		end
	end

	assign empty       = !out_valid_q;
	assign code_bit    = out_bit_q;
	assign end_of_code = out_end_q;

endmodule

FILE: rtl/crc_bit_serial_generator_top.sv
// Top level of the bit-serial CRC generator with a programmable polynomial.
// Message bits enter one per transfer, most significant first, and each one
// comes out unchanged as a code bit via the queue and the output register;
// the bit marked last is followed by the w check bits of the remainder, most
// significant first, with end_of_code set on the final one. Sustained rate is
// one message bit per cycle while the output is popped: the back end retires
// one result per cycle, but after a last bit the w check bits occupy it while
// a two-entry queue takes input until it fills. The degree w is crc_width
// clamped to 1..MAX_CRC_WIDTH, and gen_poly bits at or above w are ignored.
// Configuration writes are always ready and take effect for the next bit.
module crc_bit_serial_generator_top #(
	parameter int unsigned MAX_CRC_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           data_bit,
	input  logic                           last_bit,
	output logic                           empty,
	input  logic                           pop,
	output logic                           code_bit,
	output logic                           end_of_code,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbsg_pkg::POLY_W-1:0]    cfg_data
);

	logic [cbsg_pkg::POLY_W-1:0] gen_poly_q;
	logic [cbsg_pkg::CW_W-1:0]   crc_width_q;
	logic                        item_valid;
	logic                        item_take;
	cbsg_pkg::item_t             item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_poly_q  <= cbsg_pkg::GEN_POLY_RST;
			crc_width_q <= cbsg_pkg::CRC_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cbsg_pkg::CFG_GEN_POLY:  gen_poly_q  <= cfg_data;
				cbsg_pkg::CFG_CRC_WIDTH: crc_width_q <= cfg_data[cbsg_pkg::CW_W-1:0];
				default: ;
			endcase
		end
	end

	cbsg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_bit   (data_bit),
		.last_bit   (last_bit),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	cbsg_back #(
		.MAX_CRC_WIDTH (MAX_CRC_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.gen_poly    (gen_poly_q),
		.crc_width   (crc_width_q),
		.empty       (empty),
		.pop         (pop),
		.code_bit    (code_bit),
		.end_of_code (end_of_code)
	);

endmodule
